@@ hdl/qea_pkg.sv @@
`timescale 1ns / 1ps

package qea_pkg;

  typedef struct packed {
    logic cmd;
    logic pin_a;
    logic pin_b;
  } qea_in_t;

  typedef struct packed {
    logic signed [7:0] step;
    logic              fired;
  } qea_out_t;

  typedef struct packed {
    logic [7:0] window_ticks;
    logic [4:0] slow_limit;
    logic [4:0] fast_limit;
    logic [6:0] big_step;
    logic [6:0] huge_step;
  } qea_cfg_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_TICKS = 3'd0,
    REG_SLOW_LIMIT   = 3'd1,
    REG_FAST_LIMIT   = 3'd2,
    REG_BIG_STEP     = 3'd3,
    REG_HUGE_STEP    = 3'd4
  } qea_reg_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  localparam logic [7:0] WINDOW_TICKS_RST = 8'd200;
  localparam logic [4:0] SLOW_LIMIT_RST   = 5'd1;
  localparam logic [4:0] FAST_LIMIT_RST   = 5'd4;
  localparam logic [6:0] BIG_STEP_RST     = 7'd16;
  localparam logic [6:0] HUGE_STEP_RST    = 7'd64;

  // Gray mapping of the two pins: 00->0, 01->1, 11->2, 10->3.
  function automatic logic [1:0] gray_phase(input logic a, input logic b);
    gray_phase = {a, a ^ b};
  endfunction

endpackage

@@ hdl/quadrature_encoder_accelerated_unit.sv @@
`timescale 1ns / 1ps

// Quadrature encoder decoder with speed-dependent step acceleration.
// Input channel (in_valid/in_ready/in_data): a tick word samples pins A and B
// and moves the delta accumulator and the window counter; a poll word reads
// out an accelerated step once the window counter has run down to zero.
// Output channel (out_valid/out_ready/out_data): exactly one word per input
// word, in order, carrying the signed step and the fired flag.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no input word is in flight.
// A word accepted at an edge while the output stage is empty shows on out_data
// after that edge. Throughput is one word per cycle while in_ready is high, set
// by the single state update between the input and the output register.
// A two-word output stage lets one more input word in while a result waits;
// in_ready drops only when both output slots are full.
// Reset restores the register defaults, clears the accumulator and window
// counter, and empties the output stage. The first tick after reset records
// the pin phase and counts no motion; the window counter still steps down.

module quadrature_encoder_accelerated_unit
  import qea_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qea_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qea_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  qea_cfg_t cfg;
  qea_out_t result;
  logic     push, pop;

  qea_out_t main_r, main_nxt;
  qea_out_t skid_r, skid_nxt;
  logic     main_valid_r, main_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && in_ready;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;
  assign pop       = main_valid_r && out_ready;

  qea_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  qea_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (push),
    .in_word (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt = skid_r;
        if (push) begin
          skid_nxt = result;
        end else begin
          skid_valid_nxt = 1'b0;
        end
      end else if (push) begin
        main_nxt = result;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r) begin
        main_nxt       = result;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = result;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

@@ hdl/qea_cfg.sv @@
`timescale 1ns / 1ps

module qea_cfg
  import qea_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output qea_cfg_t            cfg
);

  qea_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_ticks <= WINDOW_TICKS_RST;
      cfg_r.slow_limit   <= SLOW_LIMIT_RST;
      cfg_r.fast_limit   <= FAST_LIMIT_RST;
      cfg_r.big_step     <= BIG_STEP_RST;
      cfg_r.huge_step    <= HUGE_STEP_RST;
    end else if (cfg_valid) begin
      // Indexes beyond the register list are dropped.
      unique case (cfg_index)
        REG_WINDOW_TICKS: cfg_r.window_ticks <= cfg_data;
        REG_SLOW_LIMIT:   cfg_r.slow_limit   <= cfg_data[4:0];
        REG_FAST_LIMIT:   cfg_r.fast_limit   <= cfg_data[4:0];
        REG_BIG_STEP:     cfg_r.big_step     <= cfg_data[6:0];
        REG_HUGE_STEP:    cfg_r.huge_step    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/qea_core.sv @@
`timescale 1ns / 1ps

module qea_core
  import qea_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  qea_in_t  in_word,
  input  qea_cfg_t cfg,
  output qea_out_t result
);

  logic [1:0] last_phase_r, last_phase_nxt;
  logic       primed_r, primed_nxt;
  logic [7:0] delta_r, delta_nxt;
  logic [7:0] window_r, window_nxt;

  logic [1:0] now_phase;
  logic [1:0] diff;
  logic [5:0] detents;
  logic [5:0] mag;
  logic       neg;
  logic [7:0] step_val;

  assign now_phase = gray_phase(in_word.pin_a, in_word.pin_b);
  assign diff      = last_phase_r - now_phase;

  // Detent count is the accumulator shifted right by two, sign kept.
  assign detents = delta_r[7:2];
  assign neg     = detents[5];
  assign mag     = neg ? (6'd0 - detents) : detents;

  always_comb begin
    if (mag <= {1'b0, cfg.slow_limit}) begin
      step_val = {{2{detents[5]}}, detents};
    end else if (mag <= {1'b0, cfg.fast_limit}) begin
      step_val = neg ? (8'd0 - {1'b0, cfg.big_step}) : {1'b0, cfg.big_step};
    end else begin
      step_val = neg ? (8'd0 - {1'b0, cfg.huge_step}) : {1'b0, cfg.huge_step};
    end
  end

  always_comb begin
    last_phase_nxt = last_phase_r;
    primed_nxt     = primed_r;
    delta_nxt      = delta_r;
    window_nxt     = window_r;
    result.step    = 8'sd0;
    result.fired   = 1'b0;
    unique case (in_word.cmd)
      CMD_TICK: begin
        if (!primed_r) begin
          last_phase_nxt = now_phase;
          primed_nxt     = 1'b1;
        end else if (diff[0]) begin
          // An even difference (no move or a skipped state) leaves the phase and the accumulator as they were.
          last_phase_nxt = now_phase;
          delta_nxt      = diff[1] ? (delta_r + 8'd1) : (delta_r - 8'd1);
        end
        window_nxt = window_r - 8'd1;
      end
      CMD_POLL: begin
        if (window_r == 8'd0) begin
          window_nxt   = cfg.window_ticks;
          delta_nxt    = {6'd0, delta_r[1:0]};
          result.step  = step_val;
          result.fired = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r <= 2'd0;
      primed_r     <= 1'b0;
      delta_r      <= 8'd0;
      window_r     <= 8'd0;
    end else if (accept) begin
      last_phase_r <= last_phase_nxt;
      primed_r     <= primed_nxt;
      delta_r      <= delta_nxt;
      window_r     <= window_nxt;
    end
  end

endmodule

@@ dv/quadrature_encoder_accelerated_unit_tb.sv @@
`timescale 1ns / 1ps

module quadrature_encoder_accelerated_unit_tb;
  import qea_pkg::*;

  // Tracks the encoder state and the settings and holds the step words still due.
  class step_scoreboard;
    logic [7:0] win_ticks;
    logic [4:0] slow_lim;
    logic [4:0] fast_lim;
    logic [6:0] big_mag;
    logic [6:0] huge_mag;
    logic [1:0] last_ph;
    bit         primed;
    logic [7:0] acc;
    logic [7:0] win_cnt;
    qea_out_t   steps_due[$];
    int         errors;
    int         words_in;

    function new();
      win_ticks = WINDOW_TICKS_RST;
      slow_lim  = SLOW_LIMIT_RST;
      fast_lim  = FAST_LIMIT_RST;
      big_mag   = BIG_STEP_RST;
      huge_mag  = HUGE_STEP_RST;
      last_ph   = 2'd0;
      primed    = 1'b0;
      acc       = 8'd0;
      win_cnt   = 8'd0;
      errors    = 0;
      words_in  = 0;
    endfunction

    function void write_reg(qea_reg_t idx, logic [7:0] data);
      case (idx)
        REG_WINDOW_TICKS: win_ticks = data;
        REG_SLOW_LIMIT:   slow_lim  = data[4:0];
        REG_FAST_LIMIT:   fast_lim  = data[4:0];
        REG_BIG_STEP:     big_mag   = data[6:0];
        REG_HUGE_STEP:    huge_mag  = data[6:0];
        default: ;
      endcase
    endfunction

    function logic [1:0] pin_phase(logic a, logic b);
      logic [1:0] p;
      p = a ? 2'd3 : 2'd0;
      if (b) p = p ^ 2'd1;
      return p;
    endfunction

    function logic signed [7:0] map_detents(int d);
      int s;
      int f;
      s = slow_lim;
      f = fast_lim;
      if (d >= -s && d <= s) return 8'(d);
      if (d > 0 && d <= f) return 8'(int'(big_mag));
      if (d < 0 && d >= -f) return 8'(-int'(big_mag));
      if (d > 0) return 8'(int'(huge_mag));
      return 8'(-int'(huge_mag));
    endfunction

    function void log_input(qea_in_t w);
      qea_out_t          r;
      logic [1:0]        now;
      logic [1:0]        diff;
      logic signed [7:0] detents;
      r.step  = 8'sd0;
      r.fired = 1'b0;
      if (w.cmd == CMD_TICK) begin
        now = pin_phase(w.pin_a, w.pin_b);
        if (!primed) begin
          last_ph = now;
          primed  = 1'b1;
        end else begin
          diff = last_ph - now;
          // An even difference means a skipped state and is ignored.
          if (diff[0]) begin
            last_ph = now;
            if (diff[1]) acc = acc + 8'd1;
            else acc = acc - 8'd1;
          end
        end
        win_cnt = win_cnt - 8'd1;
      end else if (win_cnt == 8'd0) begin
        detents = $signed(acc) >>> 2;
        win_cnt = win_ticks;
        acc     = acc & 8'd3;
        r.step  = map_detents(detents);
        r.fired = 1'b1;
      end
      steps_due.push_back(r);
      words_in++;
    endfunction

    function void check_step(qea_out_t got);
      qea_out_t want;
      if (steps_due.size() == 0) begin
        if (errors < 10)
          $display("ERROR: result word with none due: step=%0d fired=%0b",
                   got.step, got.fired);
        errors++;
        return;
      end
      want = steps_due.pop_front();
      if (got.step !== want.step || got.fired !== want.fired) begin
        if (errors < 10)
          $display("ERROR: step exp %0d got %0d, fired exp %0b got %0b",
                   want.step, got.step, want.fired, got.fired);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  qea_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  qea_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  step_scoreboard sb;

  // Shadow of the window counter, so that polls can be aimed at the moment it hits zero.
  logic [1:0] gen_ph;
  logic [7:0] gen_win;
  logic [7:0] gen_ticks_cfg;
  int         total_words;
  bit         idle_on;

  quadrature_encoder_accelerated_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(qea_reg_t'(cfg_index), cfg_data);
    if (rst_n && in_valid && in_ready) sb.log_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_step(out_data);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_word(input qea_in_t w);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.cmd == CMD_TICK) gen_win = gen_win - 8'd1;
    else if (gen_win == 8'd0) gen_win = gen_ticks_cfg;
    total_words++;
  endtask

  task automatic send_tick(input logic a, input logic b);
    qea_in_t w;
    w.cmd   = CMD_TICK;
    w.pin_a = a;
    w.pin_b = b;
    send_word(w);
  endtask

  task automatic send_poll();
    qea_in_t w;
    w.cmd   = CMD_POLL;
    w.pin_a = 1'($urandom);
    w.pin_b = 1'($urandom);
    send_word(w);
  endtask

  // A stretch of rotation at one speed, then polls. Most stretches end exactly
  // when the window runs out, so that the poll consumes the delta.
  task automatic run_burst();
    int         move_pct;
    int         n;
    int         r;
    int         polls;
    logic [1:0] dir;
    r = $urandom_range(0, 3);
    move_pct = (r == 0) ? 0 : (r == 1) ? 30 : (r == 2) ? 70 : 92;
    dir = $urandom_range(0, 1) ? 2'd1 : 2'd3;
    r = $urandom_range(0, 99);
    if (r < 75) n = gen_win;
    else if (r < 88) n = $urandom_range(0, gen_win);
    else if (r < 94) n = int'(gen_win) + $urandom_range(1, 3);
    else n = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 2) dir = 2'd0 - dir;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_tick(1'($urandom), 1'($urandom));
      end else begin
        if (r < 8) gen_ph = gen_ph + 2'd2;
        else if (r < 8 + move_pct) gen_ph = gen_ph + dir;
        send_tick(gen_ph[1], gen_ph[1] ^ gen_ph[0]);
      end
    end
    polls = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(1, 2);
    repeat (polls) send_poll();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.steps_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input qea_reg_t idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int p);
    logic [7:0] v[5];
    int         r;
    case (p)
      1: v = '{8'd0, 8'd0, 8'd0, 8'd127, 8'd127};
      2: v = '{8'd255, 8'd31, 8'd31, 8'd0, 8'd0};
      3: v = '{8'd1, 8'd0, 8'd31, 8'd127, 8'd1};
      4: v = '{8'd150, 8'd6, 8'd2, 8'd45, 8'd99};
      default: begin
        r = $urandom_range(0, 99);
        if (r < 55) v[0] = 8'($urandom_range(1, 12));
        else if (r < 70) v[0] = 8'd0;
        else v[0] = 8'($urandom_range(64, 255));
        // Upper bits of the narrow registers carry junk that must be dropped.
        v[1] = {3'($urandom), 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                            : $urandom_range(0, 6))};
        v[2] = {3'($urandom), 5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                            : $urandom_range(0, 12))};
        v[3] = 8'($urandom);
        v[4] = 8'($urandom);
      end
    endcase
    write_reg(REG_WINDOW_TICKS, v[0]);
    write_reg(REG_SLOW_LIMIT, v[1]);
    write_reg(REG_FAST_LIMIT, v[2]);
    write_reg(REG_BIG_STEP, v[3]);
    write_reg(REG_HUGE_STEP, v[4]);
    cfg_valid <= 1'b0;
    gen_ticks_cfg = v[0];
  endtask

  initial begin
    int start;
    sb = new();
    gen_ph = 2'd0;
    gen_win = 8'd0;
    gen_ticks_cfg = WINDOW_TICKS_RST;
    total_words = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Poll right after reset fires on an empty accumulator; the first tick
    // only primes the phase; one tick jumps two states; the last poll is early.
    send_poll();
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_poll();
    gen_ph = 2'd0;

    start = total_words;
    while (total_words - start < 200) run_burst();
    drain();

    for (int p = 1; total_words < 1625; p++) begin
      configure(p);
      idle_on = ($urandom_range(0, 3) != 0);
      start = total_words;
      while (total_words - start < 130) run_burst();
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.steps_due.size() != 0)
      $display("ERROR: %0d result words never arrived", sb.steps_due.size());
    if (sb.errors == 0 && sb.steps_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stalls, plus two long hold-offs that fill the block up.
  initial begin
    int gap;
    int holds;
    holds = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (holds < 2 && sb.words_in >= (holds + 1) * 500) begin
        out_ready <= 1'b0;
        repeat (64) @(posedge clk);
        holds++;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= 3000) begin
        $display("ERROR: no word moved for %0d cycles", quiet);
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
